>>> rtl/mlpq_pkg.sv
`default_nettype none

package mlpq_pkg;

  // Queue geometry
  localparam int LEVELS  = 64;
  localparam int THREADS = 64;

  localparam int LVW = $clog2(LEVELS);
  localparam int TW  = $clog2(THREADS);
  localparam int CW  = $clog2(THREADS + 1);

  // Top-level search walks the occupancy bitmap in groups of GRP bits
  localparam int GRP  = 8;
  localparam int GIW  = $clog2(GRP);
  localparam int NGRP = (LEVELS + GRP - 1) / GRP;
  localparam int GW   = (NGRP > 1) ? $clog2(NGRP) : 1;

  // Field widths
  localparam int OP_W  = 3;
  localparam int TID_W = 6;
  localparam int PRI_W = 6;
  localparam int THR_W = 6;
  localparam int ST_W  = 2;
  localparam int TOT_W = 7;

  localparam int IN_W  = 16;
  localparam int OUT_W = 24;

  localparam int TOT_MAX = (2 ** TOT_W) - 1;

  // Operation codes
  localparam logic [OP_W-1:0] OP_PUSH     = 3'd0;
  localparam logic [OP_W-1:0] OP_POP      = 3'd1;
  localparam logic [OP_W-1:0] OP_PEEK     = 3'd2;
  localparam logic [OP_W-1:0] OP_REPRIO   = 3'd3;
  localparam logic [OP_W-1:0] OP_CONTAINS = 3'd4;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY  = 2'd1;
  localparam logic [ST_W-1:0] ST_REJECT = 2'd2;

endpackage

`default_nettype wire

>>> rtl/multilevel_priority_ready_queue.sv
`default_nettype none

// Multilevel priority ready queue: one FIFO of thread ids per priority level.
// Input beats (s_axis) carry an operation, a thread id and a priority; each
// accepted beat produces exactly one result beat on m_axis.
//   push     - append thread at tail of its level (rejected if already queued)
//   pop/peek - return head of highest occupied level (pop removes it)
//   reprio   - unlink a queued thread and append it at its new level
//   contains - membership query
// Sequencing from one accepted beat to the next: push appends, pop reads the
//   head and unlinks it, reprioritize unlinks and appends, and all three then
//   walk down the 8-bit occupancy groups (1..NGRP of them) in the top-level
//   search; peek only reads the head; contains and others go straight to the
//   finish step. Each link memory has one write and one registered read port.
// s_axis_tready is high only while the sequencer is idle. The result sits in
// an output register; a new beat is accepted while it waits, and the block
// holds the next result in its finish step until the register is free.
// Reset (rst_ni low) empties the queue: occupancy and membership bits, count
// and top level clear at once; link memories need no clearing pass.
module multilevel_priority_ready_queue (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        s_axis_tvalid,
  output logic                       s_axis_tready,
  // [2:0] op, [8:3] thread_id, [14:9] priority_req, [15] zero
  input  wire  [mlpq_pkg::IN_W-1:0]  s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  wire                        m_axis_tready,
  // [5:0] thread_out, [7:6] status, [8] is_member, [9] queue_empty,
  // [16:10] queued_total, [23:17] zero
  output logic [mlpq_pkg::OUT_W-1:0] m_axis_tdata
);

  localparam int LEVELS = mlpq_pkg::LEVELS;
  localparam int THREADS = mlpq_pkg::THREADS;
  localparam int LVW = mlpq_pkg::LVW;
  localparam int TW = mlpq_pkg::TW;
  localparam int CW = mlpq_pkg::CW;
  localparam int GRP = mlpq_pkg::GRP;
  localparam int GIW = mlpq_pkg::GIW;
  localparam int GW = mlpq_pkg::GW;
  localparam int NGRP = mlpq_pkg::NGRP;

  // Sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_HR   = 4'd1;  // issue head read of top level
  localparam logic [3:0] S_HD   = 4'd2;  // head data back
  localparam logic [3:0] S_U0   = 4'd3;  // unlink: links and level of thread
  localparam logic [3:0] S_U1   = 4'd4;  // unlink: head/tail of its level
  localparam logic [3:0] S_U2   = 4'd5;  // unlink: patch links
  localparam logic [3:0] S_A0   = 4'd6;  // append: read tail of level
  localparam logic [3:0] S_A1   = 4'd7;  // append: write links
  localparam logic [3:0] S_SCAN = 4'd8;  // top-level search, one group a cycle
  localparam logic [3:0] S_FIN  = 4'd9;  // load output register

  logic [3:0] state_q, state_d;

  logic [mlpq_pkg::OP_W-1:0]  op_q, op_d;
  logic [TW-1:0]              qid_q, qid_d;   // queried id
  logic                       idok_q, idok_d;
  logic [TW-1:0]              wid_q, wid_d;   // id being linked/unlinked
  logic [LVW-1:0]             lvl_q, lvl_d;
  logic [mlpq_pkg::THR_W-1:0] thr_q, thr_d;
  logic [mlpq_pkg::ST_W-1:0]  st_q, st_d;
  logic [LEVELS-1:0]          occ_q, occ_d;
  logic [THREADS-1:0]         queued_q, queued_d;
  logic [CW-1:0]              count_q, count_d;
  logic [LVW-1:0]             top_q, top_d;
  logic [GW-1:0]              grp_q, grp_d;
  logic                       m_valid_q, m_valid_d;
  logic [mlpq_pkg::OUT_W-1:0] m_data_q, m_data_d;

  // Link memories
  logic [TW-1:0]  head_mem [LEVELS];
  logic [TW-1:0]  tail_mem [LEVELS];
  logic [TW-1:0]  next_mem [THREADS];
  logic [TW-1:0]  prev_mem [THREADS];
  logic [LVW-1:0] mlvl_mem [THREADS];

  logic [TW-1:0]  head_rd_q, tail_rd_q, next_rd_q, prev_rd_q;
  logic [LVW-1:0] mlvl_rd_q;
  logic [LVW-1:0] head_ra, tail_ra;

  logic           head_we, tail_we, next_we, prev_we, mlvl_we;
  logic [LVW-1:0] head_wa, tail_wa;
  logic [TW-1:0]  next_wa, prev_wa;
  logic [TW-1:0]  head_wd, tail_wd, next_wd, prev_wd;
  logic [LVW-1:0] mlvl_wd;

  // Input fields
  logic [mlpq_pkg::OP_W-1:0]  in_op;
  logic [mlpq_pkg::TID_W-1:0] in_tid;
  logic [mlpq_pkg::PRI_W-1:0] in_pri;
  logic [TW-1:0]              in_tid_t;
  logic [LVW-1:0]             in_lvl;
  logic                       in_idok;
  logic                       in_fire;

  logic [NGRP*GRP-1:0] occ_pad;
  logic [GRP-1:0]      grp_bits;
  logic                member;
  logic [mlpq_pkg::TOT_W-1:0] total;

  function automatic logic [GIW-1:0] enc_hi(input logic [GRP-1:0] v);
    logic [GIW-1:0] idx;
    idx = '0;
    for (int i = 0; i < GRP; i++) begin
      if (v[i]) idx = GIW'(i);
    end
    return idx;
  endfunction

  assign in_op    = s_axis_tdata[2:0];
  assign in_tid   = s_axis_tdata[8:3];
  assign in_pri   = s_axis_tdata[14:9];
  assign in_tid_t = TW'(in_tid);
  assign in_idok  = 32'(in_tid) < THREADS;
  // Priorities beyond the last level saturate
  assign in_lvl   = (32'(in_pri) >= LEVELS) ? LVW'(LEVELS - 1) : LVW'(in_pri);

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  always_comb begin
    occ_pad = '0;
    occ_pad[LEVELS-1:0] = occ_q;
  end

  assign grp_bits = occ_pad[grp_q*GRP +: GRP];
  assign member   = idok_q && queued_q[qid_q];
  assign total    = (32'(count_q) > mlpq_pkg::TOT_MAX) ? mlpq_pkg::TOT_W'(mlpq_pkg::TOT_MAX)
                                                        : mlpq_pkg::TOT_W'(count_q);

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    qid_d     = qid_q;
    idok_d    = idok_q;
    wid_d     = wid_q;
    lvl_d     = lvl_q;
    thr_d     = thr_q;
    st_d      = st_q;
    occ_d     = occ_q;
    queued_d  = queued_q;
    count_d   = count_q;
    top_d     = top_q;
    grp_d     = grp_q;
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;

    head_ra = top_q;
    tail_ra = lvl_q;
    head_we = 1'b0;  head_wa = lvl_q;  head_wd = wid_q;
    tail_we = 1'b0;  tail_wa = lvl_q;  tail_wd = wid_q;
    next_we = 1'b0;  next_wa = wid_q;  next_wd = wid_q;
    prev_we = 1'b0;  prev_wa = wid_q;  prev_wd = wid_q;
    mlvl_we = 1'b0;  mlvl_wd = lvl_q;

    if (m_valid_q && m_axis_tready) m_valid_d = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          op_d   = in_op;
          qid_d  = in_tid_t;
          idok_d = in_idok;
          wid_d  = in_tid_t;
          lvl_d  = in_lvl;
          thr_d  = '0;
          st_d   = mlpq_pkg::ST_OK;
          unique case (in_op)
            mlpq_pkg::OP_PUSH: begin
              if (!in_idok || queued_q[in_tid_t]) begin
                st_d    = mlpq_pkg::ST_REJECT;
                state_d = S_FIN;
              end else begin
                state_d = S_A0;
              end
            end
            mlpq_pkg::OP_POP, mlpq_pkg::OP_PEEK: begin
              if (count_q == '0) begin
                st_d    = mlpq_pkg::ST_EMPTY;
                state_d = S_FIN;
              end else begin
                state_d = S_HR;
              end
            end
            mlpq_pkg::OP_REPRIO: begin
              state_d = (in_idok && queued_q[in_tid_t]) ? S_U0 : S_FIN;
            end
            default: state_d = S_FIN;  // contains and unused codes
          endcase
        end
      end
      S_HR: begin
        head_ra = top_q;
        state_d = S_HD;
      end
      S_HD: begin
        thr_d = mlpq_pkg::THR_W'(head_rd_q);
        if (op_q == mlpq_pkg::OP_POP) begin
          wid_d   = head_rd_q;
          state_d = S_U0;
        end else begin
          state_d = S_FIN;
        end
      end
      S_U0: begin
        state_d = S_U1;
      end
      S_U1: begin
        head_ra = mlvl_rd_q;
        tail_ra = mlvl_rd_q;
        state_d = S_U2;
      end
      S_U2: begin
        // head_rd_q/tail_rd_q belong to the thread's level, next/prev to it
        priority if (head_rd_q == wid_q && tail_rd_q == wid_q) begin
          occ_d[mlvl_rd_q] = 1'b0;
        end else if (head_rd_q == wid_q) begin
          head_we = 1'b1;
          head_wa = mlvl_rd_q;
          head_wd = next_rd_q;
        end else if (tail_rd_q == wid_q) begin
          tail_we = 1'b1;
          tail_wa = mlvl_rd_q;
          tail_wd = prev_rd_q;
        end else begin
          next_we = 1'b1;
          next_wa = prev_rd_q;
          next_wd = next_rd_q;
          prev_we = 1'b1;
          prev_wa = next_rd_q;
          prev_wd = prev_rd_q;
        end
        queued_d[wid_q] = 1'b0;
        count_d = count_q - CW'(1);
        grp_d   = GW'(top_q >> GIW);
        state_d = (op_q == mlpq_pkg::OP_POP) ? S_SCAN : S_A0;
      end
      S_A0: begin
        tail_ra = lvl_q;
        state_d = S_A1;
      end
      S_A1: begin
        mlvl_we = 1'b1;
        mlvl_wd = lvl_q;
        prev_we = 1'b1;
        prev_wa = wid_q;
        prev_wd = occ_q[lvl_q] ? tail_rd_q : '0;
        tail_we = 1'b1;
        tail_wa = lvl_q;
        tail_wd = wid_q;
        if (occ_q[lvl_q]) begin
          next_we = 1'b1;
          next_wa = tail_rd_q;
          next_wd = wid_q;
        end else begin
          head_we = 1'b1;
          head_wa = lvl_q;
          head_wd = wid_q;
        end
        occ_d[lvl_q]    = 1'b1;
        queued_d[wid_q] = 1'b1;
        count_d = count_q + CW'(1);
        // nothing above the old top or the new level is occupied, even if
        // the old top emptied during unlink: scan down from the higher one
        grp_d   = (lvl_q > top_q) ? GW'(lvl_q >> GIW) : GW'(top_q >> GIW);
        state_d = S_SCAN;
      end
      S_SCAN: begin
        // bits above the current top are clear, so walk groups downward
        if (|grp_bits) begin
          top_d   = LVW'({grp_q, enc_hi(grp_bits)});
          state_d = S_FIN;
        end else if (grp_q == '0) begin
          top_d   = '0;
          state_d = S_FIN;
        end else begin
          grp_d = grp_q - GW'(1);
        end
      end
      S_FIN: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d      = 1'b1;
          m_data_d       = '0;
          m_data_d[5:0]  = thr_q;
          m_data_d[7:6]  = st_q;
          m_data_d[8]    = member;
          m_data_d[9]    = (count_q == '0);
          m_data_d[16:10] = total;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Link memories: one write and one registered read per cycle each
  always_ff @(posedge clk_i) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    if (tail_we) tail_mem[tail_wa] <= tail_wd;
    if (next_we) next_mem[next_wa] <= next_wd;
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    if (mlvl_we) mlvl_mem[wid_q] <= mlvl_wd;
    head_rd_q <= head_mem[head_ra];
    tail_rd_q <= tail_mem[tail_ra];
    next_rd_q <= next_mem[wid_q];
    prev_rd_q <= prev_mem[wid_q];
    mlvl_rd_q <= mlvl_mem[wid_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      occ_q     <= '0;
      queued_q  <= '0;
      count_q   <= '0;
      top_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      occ_q     <= occ_d;
      queued_q  <= queued_d;
      count_q   <= count_d;
      top_q     <= top_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    qid_q    <= qid_d;
    idok_q   <= idok_d;
    wid_q    <= wid_d;
    lvl_q    <= lvl_d;
    thr_q    <= thr_d;
    st_q     <= st_d;
    grp_q    <= grp_d;
    m_data_q <= m_data_d;
  end

`ifndef SYNTHESIS
  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(queued_q) == int'(count_q))
    else $error("queued count differs from membership bits");

  a_occ_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) == (occ_q == '0))
    else $error("level occupancy disagrees with queued count");

  a_top_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && count_q != '0) |-> occ_q[top_q])
    else $error("top level not occupied while idle");

  a_empty_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (in_op == mlpq_pkg::OP_POP || in_op == mlpq_pkg::OP_PEEK)
     && count_q == '0) |=> (st_q == mlpq_pkg::ST_EMPTY && state_q == S_FIN))
    else $error("empty pop or peek not flagged");
`endif

endmodule

`default_nettype wire

>>> dv/multilevel_priority_ready_queue_tb.sv
`timescale 1ns / 1ps

module multilevel_priority_ready_queue_tb;

  localparam int LEVELS  = mlpq_pkg::LEVELS;
  localparam int THREADS = mlpq_pkg::THREADS;
  localparam int TW      = mlpq_pkg::TW;
  localparam int LVW     = mlpq_pkg::LVW;
  localparam int OP_W    = mlpq_pkg::OP_W;
  localparam int TID_W   = mlpq_pkg::TID_W;
  localparam int PRI_W   = mlpq_pkg::PRI_W;
  localparam int THR_W   = mlpq_pkg::THR_W;
  localparam int ST_W    = mlpq_pkg::ST_W;
  localparam int TOT_W   = mlpq_pkg::TOT_W;
  localparam int TOT_MAX = mlpq_pkg::TOT_MAX;
  localparam int IN_W    = mlpq_pkg::IN_W;
  localparam int OUT_W   = mlpq_pkg::OUT_W;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int RANDOM_ITEMS = 800;
  localparam int PHASE_LEN    = 50;
  localparam int LONG_HOLD    = 500;
  localparam int HOLD_AT_BEAT = 150;
  localparam int DRAIN_CYCLES = 40;

  // expected result beat, one per accepted command
  typedef struct packed {
    logic [THR_W-1:0] thread_out;
    logic [ST_W-1:0]  status;
    logic             is_member;
    logic             queue_empty;
    logic [TOT_W-1:0] queued_total;
  } rq_result_t;

  // Shadow of the ready queue: per-level FIFOs as doubly linked lists
  class ReadyQueueScoreboard;
    bit [TW-1:0]  lvl_head[LEVELS];
    bit [TW-1:0]  lvl_tail[LEVELS];
    bit           lvl_busy[LEVELS];
    bit [TW-1:0]  link_next[THREADS];
    bit [TW-1:0]  link_prev[THREADS];
    bit [LVW-1:0] thread_lvl[THREADS];
    bit           queued[THREADS];
    int           n_queued;
    bit [LVW-1:0] top_lvl;
    rq_result_t   pending_q[$];
    int           errors;

    function void clear();
      lvl_busy = '{default: 0};
      queued   = '{default: 0};
      n_queued = 0;
      top_lvl  = '0;
      errors   = 0;
    endfunction

    function void find_top();
      top_lvl = '0;
      for (int l = LEVELS - 1; l >= 0; l--) begin
        if (lvl_busy[l]) begin
          top_lvl = l[LVW-1:0];
          break;
        end
      end
    endfunction

    function void link_tail(bit [TW-1:0] id, bit [LVW-1:0] lvl);
      thread_lvl[id] = lvl;
      link_next[id]  = '0;
      if (lvl_busy[lvl]) begin
        link_next[lvl_tail[lvl]] = id;
        link_prev[id] = lvl_tail[lvl];
      end else begin
        lvl_head[lvl] = id;
        link_prev[id] = '0;
        lvl_busy[lvl] = 1'b1;
      end
      lvl_tail[lvl] = id;
      queued[id] = 1'b1;
      n_queued++;
    endfunction

    function void unlink(bit [TW-1:0] id);
      bit [LVW-1:0] lvl;
      lvl = thread_lvl[id];
      if (lvl_head[lvl] == id && lvl_tail[lvl] == id) begin
        lvl_busy[lvl] = 1'b0;
      end else if (lvl_head[lvl] == id) begin
        lvl_head[lvl] = link_next[id];
      end else if (lvl_tail[lvl] == id) begin
        lvl_tail[lvl] = link_prev[id];
      end else begin
        link_next[link_prev[id]] = link_next[id];
        link_prev[link_next[id]] = link_prev[id];
      end
      queued[id] = 1'b0;
      if (n_queued > 0) n_queued--;
    endfunction

    // called on every accepted command beat, in order
    function void note_command(logic [OP_W-1:0] op, logic [TID_W-1:0] id,
                               logic [PRI_W-1:0] pri);
      rq_result_t r;
      r = '0;
      case (op)
        mlpq_pkg::OP_PUSH: begin
          if (queued[id]) begin
            r.status = mlpq_pkg::ST_REJECT;
          end else begin
            link_tail(id, pri);
            find_top();
          end
        end
        mlpq_pkg::OP_POP, mlpq_pkg::OP_PEEK: begin
          if (n_queued == 0) begin
            r.status = mlpq_pkg::ST_EMPTY;
          end else begin
            r.thread_out = lvl_head[top_lvl];
            if (op == mlpq_pkg::OP_POP) begin
              unlink(lvl_head[top_lvl]);
              find_top();
            end
          end
        end
        mlpq_pkg::OP_REPRIO: begin
          if (queued[id]) begin
            unlink(id);
            link_tail(id, pri);
            find_top();
          end
        end
        default: ;
      endcase
      r.is_member    = queued[id];
      r.queue_empty  = (n_queued == 0);
      r.queued_total = (n_queued > TOT_MAX) ? TOT_MAX[TOT_W-1:0] : n_queued[TOT_W-1:0];
      pending_q.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 30) $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    task check_result(logic [OUT_W-1:0] data);
      rq_result_t exp_r;
      if (pending_q.size() == 0) begin
        report($sformatf("result beat with nothing pending: %h", data));
      end else begin
        exp_r = pending_q.pop_front();
        if (data[5:0] !== exp_r.thread_out)
          report($sformatf("thread_out %0d, want %0d", data[5:0], exp_r.thread_out));
        if (data[7:6] !== exp_r.status)
          report($sformatf("status %0d, want %0d", data[7:6], exp_r.status));
        if (data[8] !== exp_r.is_member)
          report($sformatf("is_member %0b, want %0b", data[8], exp_r.is_member));
        if (data[9] !== exp_r.queue_empty)
          report($sformatf("queue_empty %0b, want %0b", data[9], exp_r.queue_empty));
        if (data[16:10] !== exp_r.queued_total)
          report($sformatf("queued_total %0d, want %0d", data[16:10],
                           exp_r.queued_total));
      end
    endtask

    // random queued thread, or -1 if the queue is empty
    function int pick_queued();
      int ids[$];
      for (int t = 0; t < THREADS; t++) if (queued[t]) ids.push_back(t);
      if (ids.size() == 0) return -1;
      return ids[$urandom_range(0, ids.size() - 1)];
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  wire              s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata = '0;
  wire              m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  wire  [OUT_W-1:0] m_axis_tdata;

  ReadyQueueScoreboard sb;
  int  cycles = 0;
  bit  no_idle = 1'b0;   // stretches with back-to-back beats on both sides

  always #5 clk_i = ~clk_i;

  multilevel_priority_ready_queue dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // result monitor: values sampled here are the ones the block saw at this edge
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  // one command beat; tvalid stays high across back-to-back beats
  task send_cmd(logic [OP_W-1:0] op, logic [TID_W-1:0] id, logic [PRI_W-1:0] pri);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, pri, id, op};   // [2:0] op, [8:3] id, [14:9] pri
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_command(op, id, pri);
  endtask

  task wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
  endtask

  // receiver: random stalls, plus one long hold-off so the block backs up
  initial begin
    int stall;
    int beats;
    beats = 0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 11);
      if (beats == HOLD_AT_BEAT) stall = LONG_HOLD;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        for (int c = 0; c < stall; c++) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      beats++;
    end
  end

  initial begin
    int mode;
    int r;
    int q;
    logic [OP_W-1:0]  op;
    logic [TID_W-1:0] id;
    logic [PRI_W-1:0] pri;

    sb = new();
    sb.clear();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty queue, field extremes, reject, middle/head unlink
    send_cmd(mlpq_pkg::OP_POP,      6'd0,  6'd0);
    send_cmd(mlpq_pkg::OP_PEEK,     6'd63, 6'd63);
    send_cmd(mlpq_pkg::OP_CONTAINS, 6'd63, 6'd0);
    send_cmd(mlpq_pkg::OP_REPRIO,   6'd7,  6'd5);    // not queued: no effect
    send_cmd(mlpq_pkg::OP_PUSH,     6'd0,  6'd0);
    send_cmd(mlpq_pkg::OP_PUSH,     6'd63, 6'd63);
    send_cmd(mlpq_pkg::OP_PUSH,     6'd63, 6'd5);    // already queued: rejected
    send_cmd(mlpq_pkg::OP_PUSH,     6'd10, 6'd63);
    send_cmd(mlpq_pkg::OP_PUSH,     6'd20, 6'd63);
    send_cmd(mlpq_pkg::OP_PUSH,     6'd30, 6'd0);
    send_cmd(mlpq_pkg::OP_PEEK,     6'd0,  6'd0);
    send_cmd(mlpq_pkg::OP_CONTAINS, 6'd63, 6'd63);
    send_cmd(mlpq_pkg::OP_REPRIO,   6'd10, 6'd63);   // middle of level, same level
    send_cmd(mlpq_pkg::OP_REPRIO,   6'd20, 6'd63);   // again, now middle -> tail
    send_cmd(mlpq_pkg::OP_REPRIO,   6'd63, 6'd0);    // head moves down
    // top level empties while a lower level in another group stays occupied
    send_cmd(mlpq_pkg::OP_PUSH,     6'd40, 6'd20);
    send_cmd(mlpq_pkg::OP_PUSH,     6'd41, 6'd50);
    send_cmd(mlpq_pkg::OP_POP,      6'd0,  6'd0);
    send_cmd(mlpq_pkg::OP_POP,      6'd0,  6'd0);
    send_cmd(mlpq_pkg::OP_REPRIO,   6'd0,  6'd1);
    send_cmd(mlpq_pkg::OP_PEEK,     6'd0,  6'd0);
    for (int k = mlpq_pkg::OP_CONTAINS + 1; k < (1 << OP_W); k++)
      send_cmd(k[OP_W-1:0], 6'd63, 6'd63); // spare op codes
    repeat (8) send_cmd(mlpq_pkg::OP_POP, 6'd30, 6'd0);
    wait_drained();

    // random: phases biased to fill, drain or mix the queue
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % PHASE_LEN == 0) begin
        if ((n / PHASE_LEN) % 5 == 4) wait_drained();
        mode    = $urandom_range(0, 2);
        no_idle = ($urandom_range(0, 3) == 0);
      end
      r   = $urandom_range(0, 99);
      id  = TID_W'($urandom_range(0, THREADS - 1));
      pri = PRI_W'($urandom_range(0, 1) ? $urandom_range(0, LEVELS - 1)
                                        : $urandom_range(60, 63));
      case (mode)
        0:       op = (r < 55) ? mlpq_pkg::OP_PUSH : (r < 65) ? mlpq_pkg::OP_POP :
                      (r < 75) ? mlpq_pkg::OP_PEEK : (r < 87) ? mlpq_pkg::OP_REPRIO :
                      (r < 97) ? mlpq_pkg::OP_CONTAINS :
                      OP_W'(mlpq_pkg::OP_CONTAINS + 1);
        1:       op = (r < 15) ? mlpq_pkg::OP_PUSH : (r < 60) ? mlpq_pkg::OP_POP :
                      (r < 70) ? mlpq_pkg::OP_PEEK : (r < 82) ? mlpq_pkg::OP_REPRIO :
                      (r < 95) ? mlpq_pkg::OP_CONTAINS :
                      OP_W'(mlpq_pkg::OP_CONTAINS + 2);
        default: op = (r < 35) ? mlpq_pkg::OP_PUSH : (r < 55) ? mlpq_pkg::OP_POP :
                      (r < 65) ? mlpq_pkg::OP_PEEK : (r < 82) ? mlpq_pkg::OP_REPRIO :
                      (r < 97) ? mlpq_pkg::OP_CONTAINS :
                      OP_W'(mlpq_pkg::OP_CONTAINS + 3);
      endcase
      // reprioritize and contains mostly target threads that are queued
      if ((op == mlpq_pkg::OP_REPRIO && $urandom_range(0, 9) < 8) ||
          (op == mlpq_pkg::OP_CONTAINS && $urandom_range(0, 1))) begin
        q = sb.pick_queued();
        if (q >= 0) id = q[TID_W-1:0];
      end
      send_cmd(op, id, pri);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
